### rtl/core/hbp_pkg.sv
// Shared types, constants and helper functions of the hash block padder.
`default_nettype none

package hbp_pkg;

	// Largest block in bytes; the narrow block is always 64 bytes.
	localparam int MAX_BLOCK_BYTES = 128;
	localparam int NARROW_BLOCK_BYTES = 64;
	localparam int POS_W = $clog2(MAX_BLOCK_BYTES);
	localparam int BS_W = POS_W + 1;
	localparam int MEM_WORDS = MAX_BLOCK_BYTES / 8;
	localparam int WADDR_W = $clog2(MEM_WORDS);

	// Length field limits in bytes and the bit count width.
	localparam int LEN_MIN = 8;
	localparam int LEN_MAX = 16;
	localparam int LEN_W = 5;
	localparam int COUNT_W = 128;

	// Stream widths.
	localparam int IDX_W = 4;
	localparam int WORD_W = 64;
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 72;
	localparam int M_PAD_W = M_TDATA_W - WORD_W - IDX_W;

	// Padding marker byte.
	localparam logic [7:0] PAD_MARK = 8'h80;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDE_BLOCK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_FIELD_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_BIG_ENDIAN = 2'd2;

	// Command queue depth.
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW = $clog2(CMDQ_DEPTH);

	typedef struct packed {
		logic wide_block;
		logic [LEN_W-1:0] length_field_bytes;
		logic length_big_endian;
	} cfg_t;

	typedef enum logic [1:0] {
		CMD_BYTE,
		CMD_FLUSH,
		CMD_END,
		CMD_END_EXTRA
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [POS_W-1:0] pos;
		logic [7:0] data;
	} cmd_t;

	typedef enum logic [1:0] {
		MRG_RAW,
		MRG_PAD,
		MRG_PAD_LEN,
		MRG_ZERO_LEN
	} merge_t;

	typedef struct packed {
		logic [WADDR_W-1:0] word;
		logic last;
		merge_t merge;
	} word_meta_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_WAIT
	} state_t;

	// Block size in bytes, rounded down to whole words.
	function automatic logic [BS_W-1:0] block_bytes(input logic wide);
		logic [BS_W-1:0] bs;
		bs = wide ? BS_W'(MAX_BLOCK_BYTES) : BS_W'(NARROW_BLOCK_BYTES);
		return bs & ~BS_W'(7);
	endfunction

	// Length field size clamped to the legal range.
	function automatic logic [LEN_W-1:0] len_bytes(input logic [LEN_W-1:0] raw);
		logic [LEN_W-1:0] l;
		l = raw;
		if (l < LEN_W'(LEN_MIN)) begin
			l = LEN_W'(LEN_MIN);
		end
		if (l > LEN_W'(LEN_MAX)) begin
			l = LEN_W'(LEN_MAX);
		end
		return l;
	endfunction

endpackage

`default_nettype wire

### rtl/core/hbp_front.sv
// Front end of the hash block padder: accepts words, tracks the fill position, issues commands.
`default_nettype none

module hbp_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire hbp_pkg::cfg_t            cfg,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [7:0]               s_tdata,
	input  wire logic [0:0]               s_tuser,
	input  wire logic                     q_full,
	output logic                          q_push,
	output hbp_pkg::cmd_t                 q_cmd
);

	logic [hbp_pkg::POS_W-1:0] fill_q;
	logic [hbp_pkg::BS_W-1:0]  bs;
	logic [hbp_pkg::LEN_W-1:0] lb;
	logic [hbp_pkg::POS_W-1:0] pos;
	logic [hbp_pkg::BS_W-1:0]  next_pos;
	logic                      block_full;

	assign bs = hbp_pkg::block_bytes(cfg.wide_block);
	assign lb = hbp_pkg::len_bytes(cfg.length_field_bytes);

	// A fill position left over from a larger block lands on the last byte.
	assign pos = (hbp_pkg::BS_W'(fill_q) >= bs) ? hbp_pkg::POS_W'(bs - 1'b1) : fill_q;
	assign next_pos = hbp_pkg::BS_W'(pos) + 1'b1;
	assign block_full = (next_pos == bs);

	assign s_tready = !q_full;
	assign q_push = s_tvalid && s_tready;

	always_comb begin
		q_cmd.pos = pos;
		q_cmd.data = s_tdata;
		if (s_tuser[0] == 1'b0) begin
			q_cmd.kind = block_full ? hbp_pkg::CMD_FLUSH : hbp_pkg::CMD_BYTE;
		end else begin
			// The length field must start at or after the byte behind the marker.
			q_cmd.kind = (next_pos > (bs - hbp_pkg::BS_W'(lb))) ?
				hbp_pkg::CMD_END_EXTRA : hbp_pkg::CMD_END;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (q_push) begin
			if (s_tuser[0] == 1'b1 || block_full) begin
				fill_q <= '0;
			end else begin
				fill_q <= hbp_pkg::POS_W'(next_pos);
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/hbp_cmd_fifo.sv
// Short command queue between the front end and the back end of the padder.
`default_nettype none

module hbp_cmd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire hbp_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output hbp_pkg::cmd_t      head_cmd
);

	hbp_pkg::cmd_t               entries_q [hbp_pkg::CMDQ_DEPTH];
	logic [hbp_pkg::CMDQ_AW-1:0] wr_ptr_q;
	logic [hbp_pkg::CMDQ_AW-1:0] rd_ptr_q;
	logic [hbp_pkg::CMDQ_AW:0]   count_q;
	logic                        do_push;
	logic                        do_pop;

	assign full = (count_q == (hbp_pkg::CMDQ_AW+1)'(hbp_pkg::CMDQ_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd = entries_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/hbp_back.sv
// Back end of the padder: block store, bit counter, padding merge and word output stage.
`default_nettype none

module hbp_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire hbp_pkg::cfg_t                   cfg,
	input  wire logic                            q_valid,
	input  wire hbp_pkg::cmd_t                   q_cmd,
	output logic                                 q_pop,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [hbp_pkg::M_TDATA_W-1:0]        m_tdata,
	output logic                                 m_tlast,
	output logic [0:0]                           m_tuser
);

	hbp_pkg::state_t state_q;
	hbp_pkg::state_t state_next;

	logic [hbp_pkg::WORD_W-1:0]  mem [hbp_pkg::MEM_WORDS];

	logic [hbp_pkg::WADDR_W-1:0] word_q;
	hbp_pkg::merge_t             merge_q;
	logic [hbp_pkg::POS_W-1:0]   pos_q;
	logic [hbp_pkg::COUNT_W-1:0] cnt_q;

	logic                        s1_valid_q;
	logic [hbp_pkg::WORD_W-1:0]  rd_data_s1;
	hbp_pkg::word_meta_t         meta_s1;

	logic                        out_valid_q;
	logic [hbp_pkg::WORD_W-1:0]  out_word_q;
	logic [hbp_pkg::IDX_W-1:0]   out_idx_q;
	logic                        out_last_q;
	logic                        out_msg_q;

	logic [hbp_pkg::BS_W-1:0]    bs;
	logic [hbp_pkg::LEN_W-1:0]   lb;
	logic [hbp_pkg::BS_W-1:0]    len_lo;
	logic [hbp_pkg::WADDR_W-1:0] words_m1;
	logic                        word_last;
	logic                        s1_move;
	logic                        s1_free;
	logic                        s1_msg;
	logic                        rd_en;
	logic                        wr_en;
	logic [hbp_pkg::WADDR_W-1:0] wr_addr;
	logic [2:0]                  wr_lane;
	logic [hbp_pkg::WORD_W-1:0]  merged;

	assign bs = hbp_pkg::block_bytes(cfg.wide_block);
	assign lb = hbp_pkg::len_bytes(cfg.length_field_bytes);
	assign len_lo = bs - hbp_pkg::BS_W'(lb);
	assign words_m1 = hbp_pkg::WADDR_W'((bs >> 3) - 1'b1);
	assign word_last = (word_q == words_m1);

	assign s1_move = s1_valid_q && (!out_valid_q || m_tready);
	assign s1_free = !s1_valid_q || s1_move;
	assign s1_msg = meta_s1.last &&
		(meta_s1.merge == hbp_pkg::MRG_PAD_LEN || meta_s1.merge == hbp_pkg::MRG_ZERO_LEN);

	// Earliest byte of a word sits in the top lane.
	assign wr_addr = q_cmd.pos[hbp_pkg::POS_W-1:3];
	assign wr_lane = ~q_cmd.pos[2:0];

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			hbp_pkg::ST_IDLE: begin
				if (q_valid && q_cmd.kind != hbp_pkg::CMD_BYTE) begin
					state_next = hbp_pkg::ST_EMIT;
				end
			end
			hbp_pkg::ST_EMIT: begin
				if (s1_free && word_last && merge_q != hbp_pkg::MRG_PAD) begin
					state_next = hbp_pkg::ST_WAIT;
				end
			end
			hbp_pkg::ST_WAIT: begin
				if (s1_free) begin
					state_next = hbp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = hbp_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		rd_en = 1'b0;
		wr_en = 1'b0;
		unique case (state_q)
			hbp_pkg::ST_IDLE: begin
				q_pop = q_valid;
				wr_en = q_valid &&
					(q_cmd.kind == hbp_pkg::CMD_BYTE || q_cmd.kind == hbp_pkg::CMD_FLUSH);
			end
			hbp_pkg::ST_EMIT: begin
				rd_en = s1_free;
			end
			hbp_pkg::ST_WAIT: begin
				rd_en = 1'b0;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// Padding and length merge applied to the word read from the store.
	always_comb begin
		logic [hbp_pkg::POS_W-1:0] p;
		logic [hbp_pkg::BS_W-1:0]  pw;
		logic [hbp_pkg::BS_W-1:0]  li_full;
		logic [3:0]                li;
		logic [7:0]                b;
		for (int j = 0; j < 8; j++) begin
			p = {meta_s1.word, 3'(j)};
			pw = hbp_pkg::BS_W'(p);
			b = rd_data_s1[hbp_pkg::WORD_W-1-8*j -: 8];
			unique case (meta_s1.merge)
				hbp_pkg::MRG_RAW: begin
					b = b;
				end
				hbp_pkg::MRG_PAD, hbp_pkg::MRG_PAD_LEN: begin
					if (p == pos_q) begin
						b = hbp_pkg::PAD_MARK;
					end else if (p > pos_q) begin
						b = 8'h00;
					end
				end
				hbp_pkg::MRG_ZERO_LEN: begin
					b = 8'h00;
				end
				default: begin
					b = 8'h00;
				end
			endcase
			li_full = cfg.length_big_endian ? (bs - 1'b1 - pw) : (pw - len_lo);
			li = li_full[3:0];
			if ((meta_s1.merge == hbp_pkg::MRG_PAD_LEN || meta_s1.merge == hbp_pkg::MRG_ZERO_LEN)
					&& pw >= len_lo) begin
				b = cnt_q[{li, 3'b000} +: 8];
			end
			merged[hbp_pkg::WORD_W-1-8*j -: 8] = b;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr][{wr_lane, 3'b000} +: 8] <= q_cmd.data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[word_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hbp_pkg::ST_IDLE;
			word_q <= '0;
			merge_q <= hbp_pkg::MRG_RAW;
			pos_q <= '0;
			cnt_q <= '0;
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (q_pop) begin
				pos_q <= q_cmd.pos;
				word_q <= '0;
				unique case (q_cmd.kind)
					hbp_pkg::CMD_FLUSH:     merge_q <= hbp_pkg::MRG_RAW;
					hbp_pkg::CMD_END:       merge_q <= hbp_pkg::MRG_PAD_LEN;
					hbp_pkg::CMD_END_EXTRA: merge_q <= hbp_pkg::MRG_PAD;
					hbp_pkg::CMD_BYTE:      merge_q <= merge_q;
					default:                merge_q <= merge_q;
				endcase
			end else if (rd_en) begin
				if (word_last) begin
					word_q <= '0;
					// The extra block that carries only the length follows the padded one.
					if (merge_q == hbp_pkg::MRG_PAD) begin
						merge_q <= hbp_pkg::MRG_ZERO_LEN;
					end
				end else begin
					word_q <= word_q + 1'b1;
				end
			end
			if (s1_move && s1_msg) begin
				cnt_q <= '0;
			end else if (wr_en) begin
				cnt_q <= cnt_q + hbp_pkg::COUNT_W'(8);
			end
			if (rd_en) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			meta_s1.word <= word_q;
			meta_s1.last <= word_last;
			meta_s1.merge <= merge_q;
		end
		if (s1_move) begin
			out_word_q <= merged;
			out_idx_q <= hbp_pkg::IDX_W'(meta_s1.word);
			out_last_q <= meta_s1.last;
			out_msg_q <= s1_msg;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {{hbp_pkg::M_PAD_W{1'b0}}, out_idx_q, out_word_q};
	assign m_tlast = out_last_q;
	assign m_tuser = out_msg_q;

`ifndef ASSERT_OFF
	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && s1_msg) |=> (cnt_q == '0))
		else $error("bit count not cleared after the final word");
	a_store_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !s1_valid_q)
		else $error("block store written while a read word is pending");
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hbp_pkg::ST_IDLE) |-> !s1_valid_q)
		else $error("command taken before the previous block has drained");
	a_msg_ends_block: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_msg_q) |-> out_last_q)
		else $error("message end flagged away from a block end");
`endif

endmodule

`default_nettype wire

### rtl/core/hash_block_padder_top.sv
// Top level of the hash block padder: configuration registers and the front, queue and back.
`default_nettype none

// Merkle-Damgard length padding front end. Each slave word carries one message
// byte (tuser low) or an end-of-message marker (tuser high). Bytes are gathered
// into 64-byte blocks, or 128-byte blocks when wide_block is set, and every full
// block leaves the master side as 8 or 16 words of 64 bits, earliest byte in the
// top bits, with the word's position in the block, tlast on the last word of a
// block and tuser on the last word of the final padded block. A 128-bit bit
// count is kept per message; the end marker appends 0x80, zero-fills, adds a
// further block when the length no longer fits, and writes the low
// length_field_bytes bytes of the count (clamped to 8..16) in the byte order set
// by length_big_endian, after which the counters return to zero. The front end
// takes one word per cycle, unless the queue is full, into a four-entry command
// queue. The back end takes each byte with a single write to the block store.
// To send a block it takes the command, reads each word on the store's read
// port, and waits while the last word leaves the read stage; the first word of
// a block passes the command queue, the state register, the read stage and the
// output register before it appears. An end marker sends one or two blocks;
// with two, the reads of the second follow those of the first without a return
// to idle. The front end stalls only while the queue is full. The block store
// needs no clearing pass after reset: every byte that is sent was written first
// or is replaced by padding or length. Configuration is written through cfg_we,
// cfg_index and cfg_data, and should only be changed while the block is idle.

module hash_block_padder_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration write port.
	input  wire logic                              cfg_we,
	input  wire logic [hbp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [hbp_pkg::LEN_W-1:0]         cfg_data,
	// Slave side.
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [hbp_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] data_byte
	input  wire logic [0:0]                        s_tuser,   // [0] mode
	// Master side.
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [hbp_pkg::M_TDATA_W-1:0]          m_tdata,   // [63:0] block_word,
	                                                          // [67:64] word_index, zero above
	output logic                                   m_tlast,   // block_done
	output logic [0:0]                             m_tuser    // [0] message_done
);

	hbp_pkg::cfg_t cfg_q;
	hbp_pkg::cmd_t push_cmd;
	hbp_pkg::cmd_t head_cmd;
	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          head_valid;

	// The configuration registers keep their values across the end of a message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wide_block <= 1'b0;
			cfg_q.length_field_bytes <= hbp_pkg::LEN_W'(hbp_pkg::LEN_MIN);
			cfg_q.length_big_endian <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hbp_pkg::CFG_WIDE_BLOCK: begin
					cfg_q.wide_block <= cfg_data[0];
				end
				hbp_pkg::CFG_LENGTH_FIELD_BYTES: begin
					cfg_q.length_field_bytes <= cfg_data;
				end
				hbp_pkg::CFG_LENGTH_BIG_ENDIAN: begin
					cfg_q.length_big_endian <= cfg_data[0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// The front end classifies each word against the current fill position.
	hbp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	hbp_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// The back end owns the block store and the bit count and sends the words.
	hbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (head_valid),
		.q_cmd    (head_cmd),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire
